@@ rtl/gyro_drift_removed_heading_hue_core_defines.svh @@
// assertion macros for the gyro heading hue core
// expects clk_i and rst_ni in the scope of use; no other dependencies
`ifndef GYRO_DRIFT_REMOVED_HEADING_HUE_CORE_DEFINES_SVH
`define GYRO_DRIFT_REMOVED_HEADING_HUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GDH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gdh assertion failed");
// next-cycle implication
`define GDH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gdh assertion failed");
`else
`define GDH_ASSERT_NOW(lbl, ante, cons)
`define GDH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/gdh_pkg.sv @@
// shared types, widths and constants of the gyro heading hue core
// no dependencies
package gdh_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int BAND_W     = 23;
  localparam int GAIN_W     = 16;
  localparam int DEV_W      = 26;
  localparam int INC_W      = DEV_W + GAIN_W + 1;
  localparam int ACC_W      = 48;
  localparam int FRAC_W     = 24;
  localparam int INT_W      = ACC_W - FRAC_W;
  localparam int HUE_W      = 9;
  localparam int REM_W      = 10;
  localparam int HUE_MOD    = 360;
  // floor(2^24 / 360), quotient may come out one low
  localparam int HUE_RECIP  = 46603;
  localparam int HUE_RCP_W  = 16;
  // output buffer, power of two
  localparam int OFIFO_DEPTH = 16;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_BAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_BAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

  localparam logic [BAND_W-1:0] INNER_RST = 23'd512;
  localparam logic [BAND_W-1:0] OUTER_RST = 23'd1280;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd655;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [BAND_W-1:0] inner_band;
    logic [BAND_W-1:0] outer_band;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [HUE_W-1:0]        hue;
    logic signed [ACC_W-1:0] angle_total;
  } res_t;

  // halve, rounding toward zero
  function automatic logic signed [DEV_W-1:0] halve_tz(input logic signed [DEV_W-1:0] d);
    logic signed [DEV_W-1:0] t;
    t = d + DEV_W'(d[DEV_W-1]);
    return t >>> 1;
  endfunction

  function automatic logic [DEV_W-1:0] mag_of(input logic signed [DEV_W-1:0] d);
    return d[DEV_W-1] ? DEV_W'(-d) : DEV_W'(d);
  endfunction

endpackage

@@ rtl/gyro_drift_removed_heading_hue_core.sv @@
// Gyro heading hue core. Takes one signed Q8 z-rate sample per beat and returns one
// result per sample: the saturating Q24 angle and its hue in 0..359. A new sample is
// accepted every cycle while results are taken. The window is a row of WINDOW_LENGTH
// sample cells that shifts once per accepted beat, so the running sum needs only one
// subtract and one add, and the angle accumulator closes in one 48-bit add per cycle;
// these two loops set the rate. Up to 16 samples may be in flight or buffered; once
// that many are outstanding, input ready drops until a result is taken. All window
// cells clear at reset, no fill pass needed. Configuration writes apply at once and
// are meant for idle periods.
// depends on gdh_pkg, gdh_cell, gdh_dev, gdh_hue, gdh_ofifo and the defines header
`include "gyro_drift_removed_heading_hue_core_defines.svh"

module gyro_drift_removed_heading_hue_core #(
  parameter int WINDOW_LENGTH = 100
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gdh_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [gdh_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [gdh_pkg::SAMPLE_W-1:0]   rate_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [gdh_pkg::HUE_W-1:0]             hue_o,
  output logic signed [gdh_pkg::ACC_W-1:0]      angle_total_o
);

  localparam int SUM_W = gdh_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int CRD_W = gdh_pkg::OFIFO_AW + 1;

  // configuration registers
  gdh_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gdh_pkg::CFG_INNER_BAND: cfg_d.inner_band = cfg_wdata_i;
        gdh_pkg::CFG_OUTER_BAND: cfg_d.outer_band = cfg_wdata_i;
        gdh_pkg::CFG_GAIN:       cfg_d.gain       = cfg_wdata_i[gdh_pkg::GAIN_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // credits bound the items in flight to the output buffer depth
  logic             in_acc, out_acc;
  logic [CRD_W-1:0] credit_q, credit_d;

  assign in_ready_o = (credit_q < CRD_W'(gdh_pkg::OFIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign credit_d   = credit_q + CRD_W'(in_acc) - CRD_W'(out_acc);

  // window cells, cell 0 takes the new sample, the last holds the oldest
  logic signed [gdh_pkg::SAMPLE_W-1:0] tap [WINDOW_LENGTH+1];

  assign tap[0] = rate_sample_i;

  for (genvar gi = 0; gi < WINDOW_LENGTH; gi++) begin : g_cell
    gdh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .d_i     (tap[gi]),
      .q_o     (tap[gi+1])
    );
  end

  // running window sum
  logic signed [SUM_W-1:0]             sum_q, sum_d;
  logic                                s_v_q;
  logic signed [gdh_pkg::SAMPLE_W-1:0] s_smp_q;

  assign sum_d = in_acc ? (sum_q - SUM_W'(tap[WINDOW_LENGTH]) + SUM_W'(rate_sample_i)) : sum_q;

  // average, deviation, damping
  logic                             dv_v;
  logic signed [gdh_pkg::DEV_W-1:0] dv_dev;

  gdh_dev #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SUM_W         (SUM_W)
  ) u_dev (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_v_q),
    .sum_i    (sum_q),
    .sample_i (s_smp_q),
    .cfg_i    (cfg_q),
    .valid_o  (dv_v),
    .dev_o    (dv_dev)
  );

  // gain multiply
  logic                             e_v_q;
  logic signed [gdh_pkg::INC_W-1:0] e_inc_q, e_inc_d;

  assign e_inc_d = gdh_pkg::INC_W'(dv_dev)
                 * gdh_pkg::INC_W'(signed'({1'b0, cfg_q.gain}));

  // saturating accumulator
  logic signed [gdh_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [gdh_pkg::ACC_W:0]   acc_sum;
  logic                             f_v_q;

  assign acc_sum = (gdh_pkg::ACC_W+1)'(acc_q) + (gdh_pkg::ACC_W+1)'(e_inc_q);

  always_comb begin
    acc_d = acc_q;
    if (e_v_q) begin
      if (acc_sum[gdh_pkg::ACC_W] != acc_sum[gdh_pkg::ACC_W-1]) begin
        acc_d = acc_sum[gdh_pkg::ACC_W] ? gdh_pkg::ACC_MIN : gdh_pkg::ACC_MAX;
      end else begin
        acc_d = acc_sum[gdh_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_band <= gdh_pkg::INNER_RST;
      cfg_q.outer_band <= gdh_pkg::OUTER_RST;
      cfg_q.gain       <= gdh_pkg::GAIN_RST;
      credit_q         <= '0;
      sum_q            <= '0;
      acc_q            <= '0;
      s_v_q            <= 1'b0;
      e_v_q            <= 1'b0;
      f_v_q            <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      credit_q <= credit_d;
      sum_q    <= sum_d;
      acc_q    <= acc_d;
      s_v_q    <= in_acc;
      e_v_q    <= dv_v;
      f_v_q    <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_smp_q <= rate_sample_i;
    e_inc_q <= e_inc_d;
  end

  // hue and output buffer
  logic          hu_v;
  gdh_pkg::res_t hu_res;
  gdh_pkg::res_t rd_res;
  logic [CRD_W-1:0] fifo_cnt;

  gdh_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_v_q),
    .angle_i (acc_q),
    .valid_o (hu_v),
    .res_o   (hu_res)
  );

  gdh_ofifo u_ofifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (hu_v),
    .wdata_i    (hu_res),
    .rd_ready_i (out_ready_i),
    .rd_valid_o (out_valid_o),
    .rdata_o    (rd_res),
    .cnt_o      (fifo_cnt)
  );

  assign hue_o         = rd_res.hue;
  assign angle_total_o = rd_res.angle_total;

  // buffered results never exceed outstanding credits
  `GDH_ASSERT_NOW(a_credit_covers_fifo, 1'b1, credit_q >= fifo_cnt)
  // a buffer write with the buffer full would mean an overflow
  `GDH_ASSERT_NOW(a_no_write_when_full, hu_v, fifo_cnt < CRD_W'(gdh_pkg::OFIFO_DEPTH))
  // hue stays wrapped
  `GDH_ASSERT_NOW(a_hue_range, out_valid_o, hue_o < gdh_pkg::HUE_W'(gdh_pkg::HUE_MOD))
  // an accepted sample with nothing leaving takes one credit
  `GDH_ASSERT_NEXT(a_credit_step, in_acc && !out_acc, credit_q == $past(credit_q) + 1'b1)

endmodule

@@ rtl/gdh_cell.sv @@
// one window cell: holds a sample and passes it on to the next cell per beat
// depends on gdh_pkg
module gdh_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  logic signed [gdh_pkg::SAMPLE_W-1:0] d_i,
  output logic signed [gdh_pkg::SAMPLE_W-1:0] q_o
);

  logic signed [gdh_pkg::SAMPLE_W-1:0] val_q, val_d;

  assign val_d = shift_i ? d_i : val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

@@ rtl/gdh_dev.sv @@
// window average by reciprocal multiply, deviation and band damping
// depends on gdh_pkg
module gdh_dev #(
  parameter int WINDOW_LENGTH = 100,
  parameter int SUM_W         = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  input  logic signed [gdh_pkg::SAMPLE_W-1:0] sample_i,
  input  gdh_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic signed [gdh_pkg::DEV_W-1:0]    dev_o
);

  localparam int PROD_W = 2 * SUM_W;
  // floor(2^SUM_W / W): quotient is exact or one low
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / 64'(WINDOW_LENGTH));
  localparam logic [SUM_W-1:0] WLEN  = SUM_W'(WINDOW_LENGTH);

  // stage a: magnitude times reciprocal
  logic                                a_v_q;
  logic [PROD_W-1:0]                   a_prod_q, a_prod_d;
  logic [SUM_W-1:0]                    a_mag_q, a_mag_d;
  logic                                a_neg_q;
  logic signed [gdh_pkg::SAMPLE_W-1:0] a_smp_q;

  assign a_mag_d  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign a_prod_d = PROD_W'(a_mag_d) * PROD_W'(RECIP);

  // stage b: estimate and its back product
  logic                                b_v_q;
  logic [SUM_W-1:0]                    b_q0_q, b_q0_d;
  logic [SUM_W-1:0]                    b_qw_q, b_qw_d;
  logic [SUM_W-1:0]                    b_mag_q;
  logic                                b_neg_q;
  logic signed [gdh_pkg::SAMPLE_W-1:0] b_smp_q;

  assign b_q0_d = a_prod_q[PROD_W-1 -: SUM_W];
  assign b_qw_d = SUM_W'(b_q0_d * WLEN);

  // stage c: correct quotient, sign it, subtract
  logic [SUM_W-1:0]                    c_rem;
  logic [SUM_W-1:0]                    c_quo;
  logic signed [gdh_pkg::SAMPLE_W:0]   c_avg;
  logic                                c_v_q;
  logic signed [gdh_pkg::DEV_W-1:0]    c_dev_q, c_dev_d;

  assign c_rem   = b_mag_q - b_qw_q;
  assign c_quo   = b_q0_q + SUM_W'(c_rem >= WLEN);
  assign c_avg   = b_neg_q ? -signed'({1'b0, c_quo[gdh_pkg::SAMPLE_W-1:0]})
                           :  signed'({1'b0, c_quo[gdh_pkg::SAMPLE_W-1:0]});
  assign c_dev_d = gdh_pkg::DEV_W'(b_smp_q) - gdh_pkg::DEV_W'(c_avg);

  // stage d: damping inside the bands
  logic signed [gdh_pkg::DEV_W-1:0] d_one, d_dev_d;
  logic                             d_v_q;
  logic signed [gdh_pkg::DEV_W-1:0] d_dev_q;

  always_comb begin
    d_one = c_dev_q;
    if (gdh_pkg::mag_of(c_dev_q) < gdh_pkg::DEV_W'(cfg_i.inner_band)) begin
      d_one = gdh_pkg::halve_tz(c_dev_q);
    end
    d_dev_d = d_one;
    if (gdh_pkg::mag_of(d_one) < gdh_pkg::DEV_W'(cfg_i.outer_band)) begin
      d_dev_d = gdh_pkg::halve_tz(d_one);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q <= a_prod_d;
    a_mag_q  <= a_mag_d;
    a_neg_q  <= sum_i[SUM_W-1];
    a_smp_q  <= sample_i;
    b_q0_q   <= b_q0_d;
    b_qw_q   <= b_qw_d;
    b_mag_q  <= a_mag_q;
    b_neg_q  <= a_neg_q;
    b_smp_q  <= a_smp_q;
    c_dev_q  <= c_dev_d;
    d_dev_q  <= d_dev_d;
  end

  assign valid_o = d_v_q;
  assign dev_o   = d_dev_q;

endmodule

@@ rtl/gdh_hue.sv @@
// angle to hue: truncate toward zero to whole degrees, reduce modulo 360
// depends on gdh_pkg
module gdh_hue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [gdh_pkg::ACC_W-1:0] angle_i,
  output logic                             valid_o,
  output gdh_pkg::res_t                    res_o
);

  localparam int MAG_W  = gdh_pkg::INT_W;
  localparam int PROD_W = MAG_W + gdh_pkg::HUE_RCP_W;

  // stage g: whole degrees and magnitude
  logic [gdh_pkg::ACC_W-1:0]           g_bias;
  logic signed [MAG_W-1:0]             g_int;
  logic                                g_v_q;
  logic [MAG_W-1:0]                    g_mag_q, g_mag_d;
  logic                                g_neg_q;
  logic signed [gdh_pkg::ACC_W-1:0]    g_ang_q;

  assign g_bias  = angle_i + {{gdh_pkg::INT_W{1'b0}}, {gdh_pkg::FRAC_W{angle_i[gdh_pkg::ACC_W-1]}}};
  assign g_int   = signed'(g_bias[gdh_pkg::ACC_W-1 -: MAG_W]);
  assign g_mag_d = g_int[MAG_W-1] ? MAG_W'(-g_int) : MAG_W'(g_int);

  // stage h: quotient estimate
  logic [PROD_W-1:0]                   h_prod;
  logic                                h_v_q;
  logic [gdh_pkg::HUE_RCP_W-1:0]       h_q0_q;
  logic [MAG_W-1:0]                    h_mag_q;
  logic                                h_neg_q;
  logic signed [gdh_pkg::ACC_W-1:0]    h_ang_q;

  assign h_prod = PROD_W'(g_mag_q) * PROD_W'(gdh_pkg::HUE_RECIP);

  // stage i: remainder, below twice the modulus
  logic [MAG_W-1:0]                    i_rem;
  logic                                i_v_q;
  logic [gdh_pkg::REM_W-1:0]           i_rem_q;
  logic                                i_neg_q;
  logic signed [gdh_pkg::ACC_W-1:0]    i_ang_q;

  assign i_rem = h_mag_q - MAG_W'(h_q0_q * MAG_W'(gdh_pkg::HUE_MOD));

  // final fixup, negative angles wrap upward
  logic [gdh_pkg::REM_W-1:0] j_r;
  logic [gdh_pkg::HUE_W-1:0] j_hue;

  always_comb begin
    j_r = i_rem_q;
    if (i_rem_q >= gdh_pkg::REM_W'(gdh_pkg::HUE_MOD)) begin
      j_r = i_rem_q - gdh_pkg::REM_W'(gdh_pkg::HUE_MOD);
    end
    j_hue = gdh_pkg::HUE_W'(j_r);
    if (i_neg_q && (j_r != '0)) begin
      j_hue = gdh_pkg::HUE_W'(gdh_pkg::REM_W'(gdh_pkg::HUE_MOD) - j_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
    end else begin
      g_v_q <= valid_i;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_mag_q <= g_mag_d;
    g_neg_q <= g_int[MAG_W-1];
    g_ang_q <= angle_i;
    h_q0_q  <= h_prod[PROD_W-1 -: gdh_pkg::HUE_RCP_W];
    h_mag_q <= g_mag_q;
    h_neg_q <= g_neg_q;
    h_ang_q <= g_ang_q;
    i_rem_q <= gdh_pkg::REM_W'(i_rem);
    i_neg_q <= h_neg_q;
    i_ang_q <= h_ang_q;
  end

  assign valid_o           = i_v_q;
  assign res_o.hue         = j_hue;
  assign res_o.angle_total = i_ang_q;

endmodule

@@ rtl/gdh_ofifo.sv @@
// output buffer for finished results; never written when full thanks to credits
// depends on gdh_pkg
module gdh_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  gdh_pkg::res_t                 wdata_i,
  input  logic                          rd_ready_i,
  output logic                          rd_valid_o,
  output gdh_pkg::res_t                 rdata_o,
  output logic [gdh_pkg::OFIFO_AW:0]    cnt_o
);

  gdh_pkg::res_t                 mem_q [gdh_pkg::OFIFO_DEPTH];
  logic [gdh_pkg::OFIFO_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [gdh_pkg::OFIFO_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [gdh_pkg::OFIFO_AW:0]    cnt_q, cnt_d;
  logic                          rd_en;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign wr_ptr_d   = wr_ptr_q + gdh_pkg::OFIFO_AW'(wr_en_i);
  assign rd_ptr_d   = rd_ptr_q + gdh_pkg::OFIFO_AW'(rd_en);
  assign cnt_d      = cnt_q + (gdh_pkg::OFIFO_AW+1)'(wr_en_i) - (gdh_pkg::OFIFO_AW+1)'(rd_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule
